// ----- src/fir37lp_pkg.sv -----
package fir37lp_pkg;

	localparam int IN_W = 12;
	localparam int OUT_W = 14;
	localparam int ECHO_W = 12;
	localparam int MAX_SAMPLE_BITS = 16;

	localparam int OUT_MIN = -880;
	localparam int OUT_MAX = 4975;

	localparam int TABLE_LEN = 37;
	localparam longint COEF_SCALE = 1000000;
	localparam longint COEF_ROUND = 500000;

	// Kaiser-window low-pass design values in millionths, symmetric about the center tap.
	localparam int DESIGN_MILLI [TABLE_LEN] = '{
		15, 162, 382, 219, -883, -2615, -3096, 136, 7163, 13132,
		9801, -7535, -31913, -43207, -18170, 52239, 150621, 237451, 272109,
		237451, 150621, 52239, -18170, -43207, -31913, -7535, 9801, 13132,
		7163, 136, -3096, -2615, -883, 219, 382, 162, 15
	};

	typedef struct packed {
		logic [IN_W-1:0] adc_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] filtered_value;
		logic [ECHO_W-1:0] raw_echo;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_TRUNC,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic trunc;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	// Scales a coefficient to fixed point, rounding halves away from zero.
	function automatic longint scale_coef(input int milli, input int frac_bits);
		longint mag;
		longint q;
		mag = (milli < 0) ? -longint'(milli) : longint'(milli);
		q = ((mag << frac_bits) + COEF_ROUND) / COEF_SCALE;
		return (milli < 0) ? -q : q;
	endfunction

endpackage

// ----- src/fir37lp_in_if.sv -----
interface fir37lp_in_if;
	logic valid;
	logic ready;
	fir37lp_pkg::in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- src/fir37lp_out_if.sv -----
interface fir37lp_out_if;
	logic valid;
	logic ready;
	fir37lp_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- src/fir37lp_ram.sv -----
module fir37lp_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 37
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/fir37lp_ctrl.sv -----
module fir37lp_ctrl #(
	parameter int TAPS = 37
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  fir37lp_pkg::status_t    status,
	output fir37lp_pkg::cmd_t       cmd,
	output logic [$clog2(TAPS)-1:0] tap
);

	localparam int TW = $clog2(TAPS);

	fir37lp_pkg::state_t st_q, st_nx;
	logic [TW-1:0] cnt_q, cnt_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fir37lp_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_nx;
			cnt_q <= cnt_nx;
		end
	end

	always_comb begin
		st_nx = st_q;
		cnt_nx = cnt_q;
		cmd = '0;
		in_ready = 1'b0;
		tap = cnt_q;
		case (st_q)
			fir37lp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					cnt_nx = '0;
					st_nx = fir37lp_pkg::ST_RUN;
				end
			end
			fir37lp_pkg::ST_RUN: begin
				cmd.issue = 1'b1;
				if (cnt_q == TW'(TAPS - 1)) begin
					cnt_nx = '0;
					st_nx = fir37lp_pkg::ST_DRAIN;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
			fir37lp_pkg::ST_DRAIN: begin
				// The drain state waits until the last read and product reach the accumulator.
				if (cnt_q == TW'(1)) begin
					st_nx = fir37lp_pkg::ST_TRUNC;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
			fir37lp_pkg::ST_TRUNC: begin
				cmd.trunc = 1'b1;
				st_nx = fir37lp_pkg::ST_LOAD;
			end
			fir37lp_pkg::ST_LOAD: begin
				if (status.out_free) begin
					cmd.load = 1'b1;
					st_nx = fir37lp_pkg::ST_IDLE;
				end
			end
			default: begin
				st_nx = fir37lp_pkg::ST_IDLE;
			end
		endcase
	end

	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> st_q == fir37lp_pkg::ST_RUN && cnt_q == '0)
		else $error("sample transfer did not start the tap sweep");

	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == fir37lp_pkg::ST_RUN && cnt_q == TW'(TAPS - 1) |=>
		st_q == fir37lp_pkg::ST_DRAIN)
		else $error("tap sweep did not end after the last tap");

	a_load_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == fir37lp_pkg::ST_LOAD && !status.out_free |=> st_q == fir37lp_pkg::ST_LOAD)
		else $error("result loaded while the output register was busy");

endmodule

// ----- src/fir37lp_datapath.sv -----
module fir37lp_datapath #(
	parameter int TAPS = 37,
	parameter int SAMPLE_BITS = 12,
	parameter int COEF_FRAC_BITS = 18
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fir37lp_pkg::cmd_t                   cmd,
	input  logic [$clog2(TAPS)-1:0]             tap,
	input  logic [fir37lp_pkg::IN_W-1:0]        adc_sample,
	output fir37lp_pkg::status_t                status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output fir37lp_pkg::out_item_t              out_data
);

	localparam int SB = SAMPLE_BITS;
	localparam int F = COEF_FRAC_BITS;
	localparam int CW = F + 2;
	localparam int TW = $clog2(TAPS);
	localparam int NW = $clog2(TAPS + 1);
	localparam int PW = SB + CW + 1;
	localparam int AW = F + SB + TW + 8;
	localparam int VW = AW - F;
	localparam int XW = fir37lp_pkg::IN_W + fir37lp_pkg::MAX_SAMPLE_BITS;
	localparam logic signed [VW-1:0] LO = VW'(fir37lp_pkg::OUT_MIN);
	localparam logic signed [VW-1:0] HI = VW'(fir37lp_pkg::OUT_MAX);

	logic signed [CW-1:0] coef_tab [TAPS];

	genvar g;
	for (g = 0; g < TAPS; g++) begin : g_coef
		if (g < fir37lp_pkg::TABLE_LEN) begin : g_tab
			assign coef_tab[g] =
				CW'(fir37lp_pkg::scale_coef(fir37lp_pkg::DESIGN_MILLI[g], F));
		end else begin : g_zero
			assign coef_tab[g] = '0;
		end
	end

	logic [XW-1:0] sample_ext;
	logic [SB-1:0] sample;
	logic [TW-1:0] wp_q, wp_nx, rp_q;
	logic [NW-1:0] fill_q;
	logic [SB-1:0] rd_data;
	logic [fir37lp_pkg::ECHO_W-1:0] raw_q;
	logic valid_s1;
	logic [TW-1:0] tap_s1;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] prod_s2;
	logic valid_s2;
	logic signed [AW-1:0] acc_q;
	logic round_up;
	logic signed [VW-1:0] val_q;
	logic signed [VW-1:0] sat_val;
	logic out_valid_q;
	fir37lp_pkg::out_item_t out_q;

	assign sample_ext = {{fir37lp_pkg::MAX_SAMPLE_BITS{1'b0}}, adc_sample};
	assign sample = sample_ext[SB-1:0];
	assign wp_nx = (wp_q == TW'(TAPS - 1)) ? '0 : wp_q + 1'b1;

	// The delay line is a ring buffer; the newest sample sits at the write pointer.
	fir37lp_ram #(
		.WIDTH(SB),
		.DEPTH(TAPS)
	) u_line (
		.clk   (clk),
		.we    (cmd.start),
		.waddr (wp_nx),
		.wdata (sample),
		.raddr (rp_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			fill_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				wp_q <= wp_nx;
				rp_q <= wp_nx;
				if (fill_q != NW'(TAPS)) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (cmd.issue) begin
				rp_q <= (rp_q == '0) ? TW'(TAPS - 1) : rp_q - 1'b1;
			end
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign prod = $signed({1'b0, rd_data}) * coef_tab[tap_s1];
	assign round_up = acc_q[AW-1] && (acc_q[F-1:0] != '0);

	always_comb begin
		sat_val = val_q;
		if (val_q < LO) begin
			sat_val = LO;
		end else if (val_q > HI) begin
			sat_val = HI;
		end
	end

	always_ff @(posedge clk) begin
		tap_s1 <= tap;
		// Entries older than the number of samples seen since reset read as zero.
		if (valid_s1 && NW'(tap_s1) < fill_q) begin
			prod_s2 <= prod;
		end else begin
			prod_s2 <= '0;
		end
		if (cmd.start) begin
			acc_q <= '0;
			raw_q <= adc_sample[fir37lp_pkg::ECHO_W-1:0];
		end else if (valid_s2) begin
			acc_q <= acc_q + AW'(prod_s2);
		end
		// Dropping the fraction floors; negative sums with a fraction step back up.
		if (cmd.trunc) begin
			val_q <= acc_q[AW-1:F] + {{(VW - 1){1'b0}}, round_up};
		end
		if (cmd.load) begin
			out_q.filtered_value <= sat_val[fir37lp_pkg::OUT_W-1:0];
			out_q.raw_echo <= raw_q;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= NW'(TAPS))
		else $error("fill count beyond the delay line length");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, wp_q} < (TW + 1)'(TAPS) && {1'b0, rp_q} < (TW + 1)'(TAPS))
		else $error("delay line pointer out of range");

	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load))
		else $error("result presented without a load command");

endmodule

// ----- src/fir_lowpass_37_tap.sv -----
// A sample transfer starts a tap sweep through the run, drain, truncate and load states; the load
// waits while the output register is still full, and a new sample is taken only after it. A single
// multiply-accumulate unit walks the delay-line RAM one tap per read cycle.
// The finished result waits in an output register, so the next sample is taken meanwhile.
// Reset (arst_n, asynchronous, active low) clears control and the fill count; taps not yet
// written since reset read as zero, so no clearing pass is needed.
module fir_lowpass_37_tap #(
	parameter int TAPS = 37,
	parameter int SAMPLE_BITS = 12,
	parameter int COEF_FRAC_BITS = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	fir37lp_in_if.sink    samples,
	fir37lp_out_if.source results
);

	fir37lp_pkg::cmd_t cmd;
	fir37lp_pkg::status_t status;
	logic [$clog2(TAPS)-1:0] tap;

	fir37lp_ctrl #(
		.TAPS(TAPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.status   (status),
		.cmd      (cmd),
		.tap      (tap)
	);

	fir37lp_datapath #(
		.TAPS           (TAPS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.tap        (tap),
		.adc_sample (samples.data.adc_sample),
		.status     (status),
		.out_valid  (results.valid),
		.out_ready  (results.ready),
		.out_data   (results.data)
	);

endmodule

// ----- tb/tb_fir_lowpass_37_tap.sv -----
`timescale 1ns / 1ps

module tb_fir_lowpass_37_tap;

	localparam int TAPS = 37;
	localparam int Q_FRAC = 18;
	localparam int LATENCY = TAPS + 5;
	localparam int RANDOM_TARGET = 600;
	localparam int CYCLE_LIMIT = 400000;

	// Kaiser low-pass design values in millionths.
	localparam int KAISER_MILLI [TAPS] = '{
		15, 162, 382, 219, -883, -2615, -3096, 136, 7163, 13132,
		9801, -7535, -31913, -43207, -18170, 52239, 150621, 237451, 272109,
		237451, 150621, 52239, -18170, -43207, -31913, -7535, 9801, 13132,
		7163, 136, -3096, -2615, -883, 219, 382, 162, 15
	};

	// Idle percentages per traffic phase: sender first, then receiver.
	localparam int SRC_IDLE [3] = '{21, 66, 0};
	localparam int SNK_IDLE [3] = '{66, 21, 0};

	typedef enum int {
		SEQ_NOISE,
		SEQ_PEAK_HIGH,
		SEQ_PEAK_LOW,
		SEQ_STEP,
		SEQ_IMPULSE,
		SEQ_NYQUIST
	} seq_kind_t;

	logic clk;
	logic arst_n;

	fir37lp_in_if samples_if();
	fir37lp_out_if results_if();

	fir_lowpass_37_tap uut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if)
	);

	logic [fir37lp_pkg::IN_W-1:0] pending_samples [$];
	fir37lp_pkg::out_item_t expected_results [$];
	logic [fir37lp_pkg::IN_W-1:0] tap_hist [TAPS];
	longint coef_q18 [TAPS];

	int n_sent = 0;
	int n_checked = 0;
	int errors = 0;
	int total_items = 0;
	int phase_b1 = 0;
	int phase_b2 = 0;
	int min_seen = 1 << 20;
	int max_seen = -(1 << 20);
	fir37lp_pkg::out_item_t want_item;
	fir37lp_pkg::out_item_t got_item;

	always #10 clk = ~clk;

	function automatic int phase_of(input int n);
		if (n < phase_b1)
			return 0;
		else if (n < phase_b2)
			return 1;
		return 2;
	endfunction

	// Shift the new sample into the history and compute the filter output for it.
	task automatic filter_sample(input logic [fir37lp_pkg::IN_W-1:0] s);
		int i;
		longint acc;
		longint val;
		fir37lp_pkg::out_item_t r;
		for (i = TAPS - 1; i > 0; i--)
			tap_hist[i] = tap_hist[i - 1];
		tap_hist[0] = s;
		acc = 0;
		for (i = 0; i < TAPS; i++)
			acc += longint'(tap_hist[i]) * coef_q18[i];
		// Drop the fraction bits of the magnitude so the result truncates toward zero.
		if (acc < 0)
			val = -((-acc) >>> Q_FRAC);
		else
			val = acc >>> Q_FRAC;
		if (val < fir37lp_pkg::OUT_MIN)
			val = fir37lp_pkg::OUT_MIN;
		if (val > fir37lp_pkg::OUT_MAX)
			val = fir37lp_pkg::OUT_MAX;
		r.filtered_value = val[fir37lp_pkg::OUT_W-1:0];
		r.raw_echo = s;
		expected_results.push_back(r);
	endtask

	// Sample driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_if.valid <= 1'b0;
			samples_if.data <= '0;
		end else begin
			if (samples_if.valid && samples_if.ready) begin
				filter_sample(samples_if.data.adc_sample);
				n_sent++;
			end
			if (!samples_if.valid || samples_if.ready) begin
				// At each phase boundary the sender holds off until the filter has drained.
				if (pending_samples.size() != 0
						&& !((n_sent == phase_b1 || n_sent == phase_b2)
							&& expected_results.size() != 0)
						&& $urandom_range(99) >= SRC_IDLE[phase_of(n_sent)]) begin
					samples_if.valid <= 1'b1;
					samples_if.data.adc_sample <= pending_samples.pop_front();
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			if (results_if.valid && results_if.ready) begin
				got_item = results_if.data;
				if (expected_results.size() == 0) begin
					$display(
						"%0t: unexpected result, expected none, got %0d / %0d",
						$time, got_item.filtered_value, got_item.raw_echo);
					errors++;
				end else begin
					want_item = expected_results.pop_front();
					if (got_item.filtered_value !== want_item.filtered_value) begin
						$display("%0t: filtered_value mismatch, expected %0d, got %0d",
							$time, want_item.filtered_value, got_item.filtered_value);
						errors++;
					end
					if (got_item.raw_echo !== want_item.raw_echo) begin
						$display("%0t: raw_echo mismatch, expected %0d, got %0d",
							$time, want_item.raw_echo, got_item.raw_echo);
						errors++;
					end
					if (int'(want_item.filtered_value) < min_seen)
						min_seen = want_item.filtered_value;
					if (int'(want_item.filtered_value) > max_seen)
						max_seen = want_item.filtered_value;
					n_checked++;
				end
			end
			results_if.ready <= ($urandom_range(99) >= SNK_IDLE[phase_of(n_sent)]);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int i;
		int k;
		int len;
		int mag;
		logic [fir37lp_pkg::IN_W-1:0] hi;
		logic [fir37lp_pkg::IN_W-1:0] lo;
		logic [fir37lp_pkg::IN_W-1:0] level;
		seq_kind_t kind;

		clk = 1'b0;
		arst_n = 1'b0;
		samples_if.valid = 1'b0;
		samples_if.data = '0;
		results_if.ready = 1'b0;

		// Q0.18 coefficients, rounded to nearest with halves away from zero.
		for (i = 0; i < TAPS; i++) begin
			mag = (KAISER_MILLI[i] < 0) ? -KAISER_MILLI[i] : KAISER_MILLI[i];
			coef_q18[i] = (longint'(mag) * (longint'(1) << Q_FRAC) + 500000) / 1000000;
			if (KAISER_MILLI[i] < 0)
				coef_q18[i] = -coef_q18[i];
			tap_hist[i] = '0;
		end

		// Directed part: first outputs against an empty history, field extremes, bit patterns.
		for (i = 0; i < 24; i++)
			pending_samples.push_back(i[0] ? 12'hFFF : 12'h000);
		pending_samples[5] = 12'd1;
		pending_samples[6] = 12'd2;
		pending_samples[7] = 12'h800;
		pending_samples[8] = 12'h7FF;
		pending_samples[9] = 12'hAAA;
		pending_samples[10] = 12'h555;
		pending_samples[11] = 12'hFFE;
		pending_samples[12] = 12'hFFF;

		// Random part: mostly structured sequences with random content, some noise.
		while (pending_samples.size() < 24 + RANDOM_TARGET) begin
			k = $urandom_range(9);
			kind = seq_kind_t'((k < 2) ? SEQ_NOISE : (k < 4) ? SEQ_PEAK_HIGH :
				(k < 6) ? SEQ_PEAK_LOW : (k < 7) ? SEQ_STEP :
				(k < 8) ? SEQ_IMPULSE : SEQ_NYQUIST);
			hi = ($urandom_range(3) == 0) ? 12'($urandom_range(4095, 2048)) : 12'hFFF;
			lo = ($urandom_range(3) == 0) ? 12'($urandom_range(300)) : 12'h000;
			case (kind)
				SEQ_NOISE: begin
					len = $urandom_range(40, 1);
					for (i = 0; i < len; i++)
						pending_samples.push_back(12'($urandom_range(4095)));
				end
				SEQ_PEAK_HIGH, SEQ_PEAK_LOW: begin
					// Line up large samples with one coefficient sign to drive the output
					// to its largest or most negative value.
					for (i = 0; i < TAPS; i++) begin
						if ((coef_q18[i] > 0) == (kind == SEQ_PEAK_HIGH))
							pending_samples.push_back(hi);
						else
							pending_samples.push_back(lo);
					end
				end
				SEQ_STEP: begin
					level = 12'($urandom_range(4095));
					len = $urandom_range(45, 30);
					for (i = 0; i < len; i++)
						pending_samples.push_back(level);
				end
				SEQ_IMPULSE: begin
					pending_samples.push_back(hi);
					len = $urandom_range(TAPS, 5);
					for (i = 0; i < len; i++)
						pending_samples.push_back(lo);
				end
				default: begin
					len = $urandom_range(45, TAPS);
					for (i = 0; i < len; i++)
						pending_samples.push_back(i[0] ? hi : lo);
				end
			endcase
		end
		total_items = pending_samples.size();
		phase_b1 = total_items / 3;
		phase_b2 = (2 * total_items) / 3;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_sent < total_items)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (3 * LATENCY) @(posedge clk);

		$display("Filtered %0d samples in three traffic phases; %0d results checked.",
			n_sent, n_checked);
		$display("Expected outputs spanned %0d to %0d, with peak and step sequences included.",
			min_seen, max_seen);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/fir37lp_pkg.sv
src/fir37lp_in_if.sv
src/fir37lp_out_if.sv
src/fir37lp_ram.sv
src/fir37lp_ctrl.sv
src/fir37lp_datapath.sv
src/fir_lowpass_37_tap.sv
tb/tb_fir_lowpass_37_tap.sv
